>>> hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and decode functions shared by the infix-to-postfix
// converter modules.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef enum logic [1:0] {
    CLS_ALNUM = 2'd0,
    CLS_OPEN  = 2'd1,
    CLS_CLOSE = 2'd2,
    CLS_OTHER = 2'd3
  } itp_cls_t;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UPR_LO = 8'h41;
  localparam logic [7:0] CH_UPR_HI = 8'h5A;
  localparam logic [7:0] CH_LWR_LO = 8'h61;
  localparam logic [7:0] CH_LWR_HI = 8'h7A;

  // Precedence codes; the lowest code stands for "no precedence" so that an
  // unsigned compare orders it below every operator.
  localparam logic [1:0] PREC_NONE = 2'd0;
  localparam logic [1:0] PREC_ADD  = 2'd1;
  localparam logic [1:0] PREC_MUL  = 2'd2;
  localparam logic [1:0] PREC_POW  = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    itp_cls_t   cls;
    logic [1:0] prec;
    logic       last;
  } itp_item_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    unique case (c) inside
      CH_PLUS, CH_MINUS: p = PREC_ADD;
      CH_STAR, CH_SLASH: p = PREC_MUL;
      CH_CARET:          p = PREC_POW;
      default:           p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
           ((c >= CH_UPR_LO) && (c <= CH_UPR_HI)) ||
           ((c >= CH_LWR_LO) && (c <= CH_LWR_HI));
  endfunction

  function automatic itp_cls_t classify(input logic [7:0] c);
    itp_cls_t k;
    if (is_alnum(c)) begin
      k = CLS_ALNUM;
    end else if (c == CH_OPEN) begin
      k = CLS_OPEN;
    end else if (c == CH_CLOSE) begin
      k = CLS_CLOSE;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

endpackage

>>> hdl/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Accepts input words, classifies each character and queues it for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
module itp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] ch
  input  logic              in_tlast,
  output logic              q_valid,
  output itp_pkg::itp_item_t q_item,
  input  logic              q_pop
);

  localparam int QDEPTH = 2;

  itp_pkg::itp_item_t entry_r [QDEPTH];
  logic               wr_ptr_r;
  logic               wr_ptr_nxt;
  logic               rd_ptr_r;
  logic               rd_ptr_nxt;
  logic [1:0]         fill_r;
  logic [1:0]         fill_nxt;
  logic               push;
  logic               pop;
  itp_pkg::itp_item_t new_item;

  assign in_tready = (fill_r != 2'(QDEPTH));
  assign q_valid   = (fill_r != 2'd0);
  assign q_item    = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    new_item.ch   = in_tdata;
    new_item.cls  = itp_pkg::classify(in_tdata);
    new_item.prec = itp_pkg::prec_of(in_tdata);
    new_item.last = in_tlast;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

>>> hdl/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// Carries out one queued character at a time against the operator stack and
// delivers the postfix words through a hold stage and an output register.
// ----------------------------------------------------------------------------
module itp_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  itp_pkg::itp_item_t q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] out_char
  output logic [1:0]        out_tuser,  // [0] has_char, [1] overflow
  output logic              out_tlast
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  state_t             post_state;
  itp_pkg::itp_item_t cur_r;

  logic [7:0]    mem [STACK_DEPTH];
  logic [7:0]    rd_r;
  logic          rd_ok_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] rd_idx;
  logic          ovf_r;
  logic          ovf_nxt;

  logic          hold_v_r;
  logic [7:0]    hold_ch_r;
  logic          out_v_r;
  logic [7:0]    out_ch_r;
  logic          out_has_r;
  logic          out_eoe_r;
  logic          out_ovf_r;

  logic          out_free;
  logic          emit_ok;
  logic          cnt_nz;
  logic          full;
  logic [1:0]    top_prec;
  logic          emit;
  logic [7:0]    emit_ch;
  logic          pop;
  logic          push;
  logic          finish_send;
  logic          move;

  assign out_free = !out_v_r || out_tready;
  assign emit_ok  = !hold_v_r || out_free;
  assign cnt_nz   = (count_r != '0);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign cnt_m1   = count_r - CW'(1);
  assign rd_idx   = cnt_m1[AW-1:0];
  assign top_prec = itp_pkg::prec_of(rd_r);
  assign post_state = cur_r.last ? S_FLUSH : S_FINISH;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign move     = (emit && hold_v_r) || finish_send;

  always_comb begin
    state_nxt   = state_r;
    emit        = 1'b0;
    emit_ch     = rd_r;
    pop         = 1'b0;
    push        = 1'b0;
    finish_send = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        unique case (cur_r.cls)
          itp_pkg::CLS_ALNUM: begin
            if (emit_ok) begin
              emit      = 1'b1;
              emit_ch   = cur_r.ch;
              state_nxt = post_state;
            end
          end
          itp_pkg::CLS_OPEN: begin
            push      = 1'b1;
            state_nxt = post_state;
          end
          itp_pkg::CLS_CLOSE: begin
            if (!cnt_nz) begin
              state_nxt = post_state;
            end else if (rd_ok_r) begin
              if (rd_r != itp_pkg::CH_OPEN) begin
                if (emit_ok) begin
                  emit = 1'b1;
                  pop  = 1'b1;
                end
              end else begin
                pop       = 1'b1;
                state_nxt = post_state;
              end
            end
          end
          default: begin
            if (!cnt_nz || rd_ok_r) begin
              if (cnt_nz && (cur_r.prec <= top_prec)) begin
                if (emit_ok) begin
                  emit = 1'b1;
                  pop  = 1'b1;
                end
              end else begin
                push      = 1'b1;
                state_nxt = post_state;
              end
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (!cnt_nz) begin
          state_nxt = S_FINISH;
        end else if (rd_ok_r && emit_ok) begin
          emit = 1'b1;
          pop  = 1'b1;
        end
      end
      S_FINISH: begin
        if (!hold_v_r && !cur_r.last) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          finish_send = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !full) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = cnt_m1;
    end
    ovf_nxt = ovf_r;
    if (push && full) begin
      ovf_nxt = 1'b1;
    end else if (finish_send && cur_r.last) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_ok_r  <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      rd_ok_r <= !(push || pop);
      if (emit) begin
        hold_v_r <= 1'b1;
      end else if (finish_send) begin
        hold_v_r <= 1'b0;
      end
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_item;
    end
    if (emit) begin
      hold_ch_r <= emit_ch;
    end
    if (move) begin
      out_ch_r  <= hold_v_r ? hold_ch_r : itp_pkg::CH_NUL;
      out_has_r <= hold_v_r;
      out_eoe_r <= finish_send && cur_r.last;
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[count_r[AW-1:0]] <= cur_r.ch;
    end
    rd_r <= mem[rd_idx];
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_ch_r;
  assign out_tuser  = {out_ovf_r, out_has_r};
  assign out_tlast  = out_eoe_r;

endmodule

>>> hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from an infix character stream to postfix.
// ----------------------------------------------------------------------------
// Characters enter on the input stream, one per word, with tlast on the final
// character of an expression, and land in a two-entry queue. The back end
// takes one character at a time. Every operator popped from the stack waits
// for the new top, because the stack memory has a registered read port.
// A stalled output holds the back end while a word waits.
// On the last character the stack is flushed, and the final word carries
// tlast; tuser[0] tells whether tdata holds a character and tuser[1] reports a
// dropped push since the start of the expression.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [0] has_char, [1] overflow
  output logic       out_tlast
);

  logic               q_valid;
  logic               q_pop;
  itp_pkg::itp_item_t q_item;

  itp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hdl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the infix-to-postfix converter, bound to the top.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output word shown right after reset");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("word without a character that does not end an expression");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 8'h00))
    else $error("word without a character carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |=>
      (in_tvalid && $stable(in_tdata) && $stable(in_tlast)))
    else $error("stalled input word changed");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
